>>> hdl/lfc_pkg.sv
// Shared constants, request/response and scan-unit types for the LFU cache table.
`default_nettype none
package lfc_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 5;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int SCAN_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;
  } rsp_t;

  // One entry as seen by the scan compare unit.
  typedef struct packed {
    logic                  valid;
    logic [DATA_W-1:0]     key;
    logic [COUNT_BITS-1:0] cnt;
    logic [RANK_W-1:0]     rank;
  } entry_t;

  // Current eviction candidate.
  typedef struct packed {
    logic                  ok;
    logic [COUNT_BITS-1:0] cnt;
    logic [RANK_W-1:0]     rank;
  } best_t;

  typedef struct packed {
    logic match;
    logic free;
    logic better;
  } flags_t;

endpackage
`default_nettype wire

>>> hdl/lfc_scan_cmp.sv
// Shared compare unit: key match, first free slot and victim ranking for one entry.
`default_nettype none
module lfc_scan_cmp (
  input  wire logic [lfc_pkg::DATA_W-1:0] target,
  input  wire lfc_pkg::entry_t            entry,
  input  wire lfc_pkg::best_t             best,
  input  wire logic                       found,
  input  wire logic                       free_ok,
  output lfc_pkg::flags_t                 flags
);

  always_comb begin
    flags.match  = entry.valid && (entry.key == target) && !found;
    flags.free   = !entry.valid && !free_ok;
    // lower count wins; on equal count the older (larger rank) wins
    flags.better = entry.valid && (!best.ok || (entry.cnt < best.cnt) ||
                   ((entry.cnt == best.cnt) && (entry.rank > best.rank)));
  end

endmodule
`default_nettype wire

>>> hdl/lfu_cache_table.sv
// Top level of the LFU cache table: sequencer, entry storage and result register.
//
//   channel    ports                      handshake
//   --------   ------------------------   ---------------------------------
//   request    req (op, key, value)       taken when start && !busy
//   response   rsp (hit, read_value,      valid for one cycle while done is
//              evicted, evicted_key)      high; the receiver cannot stall
//   config     cfg_data (capacity)        written when cfg_write is high
//
// Sequence: the scan state reads each entry into the read stage and ranks it in the
// compare stage, then the update state commits and registers the response strobe.
// The scan walks the key/value memory one entry a cycle through its single
// read port, and one compare unit ranks each entry.
// busy is high from the accept edge through the update cycle and drops in the
// response cycle, so the next request may be taken at the edge that retires
// the response.
// Reset (rst, synchronous): clears all valid bits, the fill count and the
// sequencer, and sets the capacity to 16. No clearing pass is needed.
`default_nettype none
module lfu_cache_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire lfc_pkg::req_t             req,
  input  wire logic                      cfg_write,
  input  wire logic [lfc_pkg::CAP_W-1:0] cfg_data,
  output logic                           done,
  output lfc_pkg::rsp_t                  rsp
);

  localparam int IW = lfc_pkg::IDX_W;
  localparam int RW = lfc_pkg::RANK_W;
  localparam int CB = lfc_pkg::COUNT_BITS;
  localparam int DW = lfc_pkg::DATA_W;
  localparam int N  = lfc_pkg::ENTRIES;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state;

  // Configuration and occupancy
  logic [lfc_pkg::CAP_W-1:0]  capacity;
  logic [lfc_pkg::FILL_W-1:0] filled, filled_next;

  // Entry storage: key/value in memory, bookkeeping in per-entry lanes
  logic [DW-1:0] key_mem   [N];
  logic [DW-1:0] value_mem [N];
  logic [N-1:0]  valid;
  logic [N-1:0]  valid_next;
  logic [CB-1:0] count      [N];
  logic [CB-1:0] count_next [N];
  logic [RW-1:0] rank       [N];
  logic [RW-1:0] rank_next  [N];

  // Latched request
  lfc_pkg::req_t req_q;

  // Scan pipeline: read stage then compare stage
  logic [lfc_pkg::SCAN_W-1:0] scan_cnt;
  logic                       scan_end;
  logic [IW-1:0]              ra;
  logic                       p_live;
  logic [IW-1:0]              p_idx;
  logic                       p_valid;
  logic [CB-1:0]              p_cnt;
  logic [RW-1:0]              p_rank;
  logic [DW-1:0]              key_rd;
  logic [DW-1:0]              value_rd;

  // Scan results
  logic          found;
  logic [IW-1:0] e_idx;
  logic [CB-1:0] e_cnt;
  logic [RW-1:0] e_rank;
  logic [DW-1:0] hit_value;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] vic_idx;
  logic [DW-1:0] vkey;
  lfc_pkg::best_t  best;
  lfc_pkg::entry_t cur;
  lfc_pkg::flags_t flags;

  // Update-cycle decisions
  logic [lfc_pkg::CMP_W-1:0] cap_eff;
  logic                      cap_nz;
  logic                      fill_lt_cap;
  logic                      do_touch;
  logic                      do_insert;
  logic                      use_free;
  logic                      use_vic;
  logic [IW-1:0]             slot;
  logic                      mem_we;
  logic [IW-1:0]             mem_addr;
  lfc_pkg::rsp_t             rsp_next;

  assign busy     = (state != ST_IDLE);
  assign scan_end = (scan_cnt == lfc_pkg::SCAN_W'(N));
  assign ra       = scan_cnt[IW-1:0];

  // Clamp the capacity to the table size and compare against the fill.
  always_comb begin
    cap_eff = lfc_pkg::CMP_W'(capacity);
    if (cap_eff > lfc_pkg::CMP_W'(N)) begin
      cap_eff = lfc_pkg::CMP_W'(N);
    end
    cap_nz      = (cap_eff != '0);
    fill_lt_cap = (lfc_pkg::CMP_W'(filled) < cap_eff);
  end

  // Compare stage input
  assign cur.valid = p_valid;
  assign cur.key   = key_rd;
  assign cur.cnt   = p_cnt;
  assign cur.rank  = p_rank;

  lfc_scan_cmp u_cmp (
    .target  (req_q.key),
    .entry   (cur),
    .best    (best),
    .found   (found),
    .free_ok (free_ok),
    .flags   (flags)
  );

  // Update: touch a hit entry, or fill / replace a slot on an absent-key put.
  always_comb begin
    valid_next  = valid;
    count_next  = count;
    rank_next   = rank;
    filled_next = filled;
    mem_we      = 1'b0;
    mem_addr    = e_idx;
    slot        = free_idx;

    do_touch  = found && ((req_q.op == lfc_pkg::OP_GET) || cap_nz);
    do_insert = !found && (req_q.op == lfc_pkg::OP_PUT) && cap_nz;
    use_free  = do_insert && fill_lt_cap && free_ok;
    use_vic   = do_insert && !use_free && best.ok;
    if (use_vic) begin
      slot = vic_idx;
    end

    rsp_next.hit         = found;
    rsp_next.read_value  = (found && (req_q.op == lfc_pkg::OP_GET)) ? hit_value : '1;
    rsp_next.evicted     = use_vic;
    rsp_next.evicted_key = use_vic ? vkey : '0;

    if (state == ST_UPDATE) begin
      if (do_touch) begin
        // saturate the use count, then age everything newer than the hit entry
        if (e_cnt != '1) begin
          count_next[e_idx] = e_cnt + CB'(1);
        end
        for (int i = 0; i < N; i++) begin
          if (valid[i] && (IW'(i) != e_idx) && (rank[i] < e_rank)) begin
            rank_next[i] = rank[i] + RW'(1);
          end
        end
        rank_next[e_idx] = '0;
        mem_we           = (req_q.op == lfc_pkg::OP_PUT);
      end else if (use_free || use_vic) begin
        // close the victim's gap in the ranking, then age all survivors
        for (int i = 0; i < N; i++) begin
          if (valid[i] && (IW'(i) != slot)) begin
            rank_next[i] = rank[i] - RW'(use_vic && (rank[i] > best.rank)) + RW'(1);
          end
        end
        valid_next[slot] = 1'b1;
        count_next[slot] = CB'(1);
        rank_next[slot]  = '0;
        mem_we           = 1'b1;
        mem_addr         = slot;
        if (use_free) begin
          filled_next = filled + lfc_pkg::FILL_W'(1);
        end
      end
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= lfc_pkg::CAP_RESET;
      filled   <= '0;
      done     <= 1'b0;
      p_live   <= 1'b0;
      scan_cnt <= '0;
      found    <= 1'b0;
      free_ok  <= 1'b0;
      best.ok  <= 1'b0;
      valid    <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
            p_live   <= 1'b0;
            found    <= 1'b0;
            free_ok  <= 1'b0;
            best.ok  <= 1'b0;
          end
        end
        ST_SCAN: begin
          // advance the read pointer; the compare stage works on the entry read in the previous cycle
          p_live <= !scan_end;
          if (scan_end) begin
            state <= ST_UPDATE;
          end else begin
            scan_cnt <= scan_cnt + lfc_pkg::SCAN_W'(1);
          end
          if (p_live) begin
            if (flags.match) begin
              found <= 1'b1;
            end
            if (flags.free) begin
              free_ok <= 1'b1;
            end
            if (flags.better) begin
              best.ok   <= 1'b1;
              best.cnt  <= p_cnt;
              best.rank <= p_rank;
            end
          end
        end
        ST_UPDATE: begin
          state  <= ST_IDLE;
          done   <= 1'b1;
          filled <= filled_next;
          valid  <= valid_next;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      req_q <= req;
    end
    if ((state == ST_SCAN) && !scan_end) begin
      key_rd   <= key_mem[ra];
      value_rd <= value_mem[ra];
      p_valid  <= valid[ra];
      p_cnt    <= count[ra];
      p_rank   <= rank[ra];
      p_idx    <= ra;
    end
    if ((state == ST_SCAN) && p_live) begin
      if (flags.match) begin
        e_idx     <= p_idx;
        e_cnt     <= p_cnt;
        e_rank    <= p_rank;
        hit_value <= value_rd;
      end
      if (flags.free) begin
        free_idx <= p_idx;
      end
      if (flags.better) begin
        vic_idx <= p_idx;
        vkey    <= key_rd;
      end
    end
    if (state == ST_UPDATE) begin
      rsp   <= rsp_next;
      count <= count_next;
      rank  <= rank_next;
    end
    if (mem_we) begin
      key_mem[mem_addr]   <= req_q.key;
      value_mem[mem_addr] <= req_q.value;
    end
  end

`ifndef SYNTHESIS
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("response strobe without an update cycle");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(filled))
    else $error("fill count disagrees with valid bits");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(filled) <= N)
    else $error("fill count beyond table size");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.evicted) |-> !rsp.hit)
    else $error("eviction reported on a hit");
`endif

endmodule
`default_nettype wire

>>> tb/tb_lfu_cache_table.sv
// Self-checking testbench for the LFU cache table: queued stimulus, predictor and response check.
`timescale 1ns / 100ps

module tb_lfu_cache_table;

  // Allow at most this many quiet cycles with no accept and no response before declaring the block hung.
  localparam int IDLE_LIMIT    = 2000;
  // Idle edges to see before a capacity write; every request answers, so keep it short.
  localparam int SETTLE_CYCLES = 3;
  localparam int RANDOM_PER_CAP = 176;
  localparam int SAT_GETS       = 32;   // enough hits to lift one use count far above another

  typedef enum logic [1:0] {STEP_ACCESS, STEP_CAPACITY, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t                kind;
    lfc_pkg::req_t             req;
    logic [lfc_pkg::CAP_W-1:0] cap;
    int                        gap;      // cycles to wait after the previous request is taken
  } plan_step_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic start     = 1'b0;
  logic cfg_write = 1'b0;
  logic [lfc_pkg::CAP_W-1:0] cfg_data = '0;
  lfc_pkg::req_t req = '0;
  logic busy;
  logic done;
  lfc_pkg::rsp_t rsp;

  lfu_cache_table uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .done      (done),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cache image kept by the testbench. Ages: 0 is the most recent entry.
  // ---------------------------------------------------------------------------
  logic                           slot_used [lfc_pkg::ENTRIES];
  logic [lfc_pkg::DATA_W-1:0]     slot_key  [lfc_pkg::ENTRIES];
  logic [lfc_pkg::DATA_W-1:0]     slot_val  [lfc_pkg::ENTRIES];
  logic [lfc_pkg::COUNT_BITS-1:0] slot_hits [lfc_pkg::ENTRIES];
  logic [lfc_pkg::RANK_W-1:0]     slot_age  [lfc_pkg::ENTRIES];
  logic [lfc_pkg::FILL_W-1:0]     slots_filled;
  logic [lfc_pkg::CAP_W-1:0]      cap_setting;

  plan_step_t    access_plan[$];
  lfc_pkg::rsp_t cache_answers[$];
  logic [31:0]   key_pool[$];
  logic [31:0]   corner_keys[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
  int            phase_caps[10] = '{16, 1, 31, 0, 7, 17, 3, 12, 2, 16};

  int   accepted_total = 0;
  int   retired_total  = 0;
  int   idle_cycles    = 0;
  int   mismatches     = 0;
  logic driver_idle    = 1'b0;

  // Raise the use count (stop at the top) and move the entry to the front.
  function automatic void bump_entry(input int e);
    logic [lfc_pkg::RANK_W-1:0] old_age;
    old_age = slot_age[e];
    if (slot_hits[e] != '1) slot_hits[e] = slot_hits[e] + 1'b1;
    for (int i = 0; i < lfc_pkg::ENTRIES; i++)
      if (slot_used[i] && i != e && slot_age[i] < old_age) slot_age[i] = slot_age[i] + 1'b1;
    slot_age[e] = '0;
  endfunction

  // Lowest use count wins; on a tie the oldest; on a full tie the lowest slot.
  function automatic int lfu_victim();
    int v;
    v = -1;
    for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
      if (!slot_used[i]) continue;
      if (v < 0 || slot_hits[i] < slot_hits[v] ||
          (slot_hits[i] == slot_hits[v] && slot_age[i] > slot_age[v]))
        v = i;
    end
    return v;
  endfunction

  // Apply one request to the cache image and return the answer it owes.
  function automatic lfc_pkg::rsp_t cache_access(input lfc_pkg::req_t r);
    lfc_pkg::rsp_t              ans;
    int                         found;
    int                         slot;
    int                         lim;
    logic [lfc_pkg::RANK_W-1:0] gone_age;
    ans.hit         = 1'b0;
    ans.read_value  = '1;
    ans.evicted     = 1'b0;
    ans.evicted_key = '0;
    found = -1;
    for (int i = lfc_pkg::ENTRIES - 1; i >= 0; i--)
      if (slot_used[i] && slot_key[i] == r.key) found = i;
    lim = (cap_setting > lfc_pkg::ENTRIES) ? lfc_pkg::ENTRIES : int'(cap_setting);
    if (found >= 0) ans.hit = 1'b1;

    if (r.op == lfc_pkg::OP_GET) begin
      if (found >= 0) begin
        ans.read_value = slot_val[found];
        bump_entry(found);
      end
    end else if (lim != 0) begin
      if (found >= 0) begin
        slot_val[found] = r.value;
        bump_entry(found);
      end else begin
        slot = -1;
        // Take a free slot only while the fill is below the capacity.
        if (slots_filled < lim) begin
          for (int i = lfc_pkg::ENTRIES - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
          if (slot >= 0) slots_filled = slots_filled + 1'b1;
        end
        // Otherwise drop the victim and close the gap it leaves in the ages.
        if (slot < 0) begin
          slot = lfu_victim();
          if (slot >= 0) begin
            gone_age        = slot_age[slot];
            ans.evicted     = 1'b1;
            ans.evicted_key = slot_key[slot];
            slot_used[slot] = 1'b0;
            for (int i = 0; i < lfc_pkg::ENTRIES; i++)
              if (slot_used[i] && slot_age[i] > gone_age) slot_age[i] = slot_age[i] - 1'b1;
          end
        end
        if (slot >= 0) begin
          for (int i = 0; i < lfc_pkg::ENTRIES; i++)
            if (slot_used[i]) slot_age[i] = slot_age[i] + 1'b1;
          slot_used[slot] = 1'b1;
          slot_key[slot]  = r.key;
          slot_val[slot]  = r.value;
          slot_hits[slot] = lfc_pkg::COUNT_BITS'(1);
          slot_age[slot]  = '0;
        end
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic plan_access(input logic op, input logic [31:0] key, input logic [31:0] value,
                             input int gap);
    plan_step_t s;
    s.kind      = STEP_ACCESS;
    s.req.op    = op;
    s.req.key   = key;
    s.req.value = value;
    s.cap       = '0;
    s.gap       = gap;
    access_plan.push_back(s);
  endtask

  task automatic plan_capacity(input logic [lfc_pkg::CAP_W-1:0] cap);
    plan_step_t s;
    s.kind = STEP_CAPACITY;
    s.req  = '0;
    s.cap  = cap;
    s.gap  = 0;
    access_plan.push_back(s);
  endtask

  task automatic plan_drain();
    plan_step_t s;
    s.kind = STEP_DRAIN;
    s.req  = '0;
    s.cap  = '0;
    s.gap  = 0;
    access_plan.push_back(s);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: take steps off the plan in order. A request stays on the port with
  // start high until an edge sees busy low. Capacity writes and drains wait
  // until every request taken so far has answered.
  // ---------------------------------------------------------------------------
  logic launch;
  logic write_now;
  logic wait_loaded;
  int   wait_left;
  int   settle;

  always @(posedge clk) begin
    if (rst) begin
      start       <= 1'b0;
      cfg_write   <= 1'b0;
      cfg_data    <= '0;
      req         <= '0;
      driver_idle <= 1'b0;
      wait_loaded = 1'b0;
      wait_left   = 0;
      settle      = 0;
    end else begin
      // Hold a request that the block has not taken yet.
      launch    = start && busy;
      write_now = 1'b0;
      if (!start && !busy && accepted_total == retired_total) settle++;
      else settle = 0;

      if (!launch && access_plan.size() != 0) begin
        if (!wait_loaded) begin
          wait_left   = access_plan[0].gap;
          wait_loaded = 1'b1;
        end
        if (wait_left > 0) begin
          wait_left--;
        end else begin
          case (access_plan[0].kind)
            STEP_ACCESS: begin
              req <= access_plan[0].req;
              launch = 1'b1;
              void'(access_plan.pop_front());
              wait_loaded = 1'b0;
            end
            STEP_CAPACITY: begin
              if (settle >= SETTLE_CYCLES) begin
                cfg_data <= access_plan[0].cap;
                write_now = 1'b1;
                void'(access_plan.pop_front());
                wait_loaded = 1'b0;
              end
            end
            STEP_DRAIN: begin
              if (!start && accepted_total == retired_total) begin
                void'(access_plan.pop_front());
                wait_loaded = 1'b0;
              end
            end
            default: begin
              void'(access_plan.pop_front());
              wait_loaded = 1'b0;
            end
          endcase
        end
      end

      start       <= launch;
      cfg_write   <= write_now;
      driver_idle <= (access_plan.size() == 0) && !launch;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: retire responses against the oldest prediction first, then track
  // capacity writes and predict for a request taken at this edge. Also run the
  // watchdog on edges where nothing moves.
  // ---------------------------------------------------------------------------
  lfc_pkg::rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_hits[i] = '0;
        slot_age[i]  = '0;
      end
      slots_filled = '0;
      cap_setting  = lfc_pkg::CAP_RESET;
      cache_answers.delete();
      accepted_total <= 0;
      retired_total  <= 0;
      idle_cycles    <= 0;
    end else begin
      if (done) begin
        if (cache_answers.size() == 0) begin
          report_mismatch("response with no request pending", rsp.read_value, '0);
        end else begin
          want = cache_answers.pop_front();
          if (rsp.hit !== want.hit) report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.evicted !== want.evicted)
            report_mismatch("evicted", 32'(rsp.evicted), 32'(want.evicted));
          if (rsp.evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", rsp.evicted_key, want.evicted_key);
          retired_total <= retired_total + 1;
        end
      end

      if (cfg_write) cap_setting = cfg_data;

      if (start && !busy) begin
        cache_answers.push_back(cache_access(req));
        accepted_total <= accepted_total + 1;
      end

      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[lfu_cache_table] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int          pool_size;
    int          eff_cap;
    logic [31:0] pick;
    bit          burst;

    // Directed: corner keys and values on an empty table, hits, an update in place.
    plan_access(lfc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 0);
    plan_access(lfc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(0, 18));
    plan_access(lfc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    plan_access(lfc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000, $urandom_range(0, 18));
    plan_access(lfc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    plan_access(lfc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 0);
    plan_access(lfc_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 18));
    plan_access(lfc_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678, 0);
    plan_access(lfc_pkg::OP_GET, 32'h1357_9BDF, 32'h0000_0000, 0);
    // Drop capacity below the fill: a new key must evict and reuse a slot.
    plan_capacity(2);
    plan_access(lfc_pkg::OP_PUT, 32'h0000_00AA, 32'hA5A5_A5A5, 0);
    plan_access(lfc_pkg::OP_PUT, 32'h8000_0000, 32'h5A5A_5A5A, 0);
    plan_access(lfc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 0);
    // Zero capacity: puts change nothing but still report presence.
    plan_capacity(0);
    plan_access(lfc_pkg::OP_PUT, 32'h0000_00AA, 32'h0000_0001, 0);
    plan_access(lfc_pkg::OP_PUT, 32'h5555_5555, 32'h0000_0002, 0);
    plan_access(lfc_pkg::OP_GET, 32'h5555_5555, 32'h0000_0000, 0);
    plan_access(lfc_pkg::OP_GET, 32'h0000_00AA, 32'h0000_0000, 0);
    // Largest register value acts as the full table.
    plan_capacity(31);
    plan_access(lfc_pkg::OP_PUT, 32'h5555_5555, 32'hCAFE_F00D, 0);
    plan_capacity(1);
    plan_access(lfc_pkg::OP_PUT, 32'h0000_1111, 32'h0000_0011, 0);
    plan_access(lfc_pkg::OP_PUT, 32'h0000_2222, 32'h0000_0022, 0);
    plan_access(lfc_pkg::OP_GET, 32'h0000_1111, 32'h0000_0000, 0);
    plan_access(lfc_pkg::OP_GET, 32'h0000_2222, 32'h0000_0000, 0);
    plan_drain();

    // Frequency: hammer one key with no gaps, then check that it outlives a
    // lightly used neighbor at eviction.
    plan_capacity(2);
    plan_access(lfc_pkg::OP_PUT, 32'h0F0F_0F0F, 32'h0000_0A0A, 0);
    plan_access(lfc_pkg::OP_PUT, 32'hF0F0_F0F0, 32'h0000_0B0B, 0);
    repeat (SAT_GETS) plan_access(lfc_pkg::OP_GET, 32'h0F0F_0F0F, $urandom(), 0);
    repeat (2) plan_access(lfc_pkg::OP_GET, 32'hF0F0_F0F0, $urandom(), 0);
    plan_access(lfc_pkg::OP_PUT, 32'h3C3C_3C3C, 32'h0000_0C0C, 0);
    plan_access(lfc_pkg::OP_GET, 32'h0F0F_0F0F, 32'h0000_0000, 0);
    plan_access(lfc_pkg::OP_GET, 32'hF0F0_F0F0, 32'h0000_0000, 0);

    // Random: per capacity setting, draw keys mostly from a pool a little
    // larger than the effective capacity so hits, updates and evictions all happen.
    foreach (phase_caps[p]) begin
      plan_capacity(lfc_pkg::CAP_W'(phase_caps[p]));
      eff_cap   = (phase_caps[p] > lfc_pkg::ENTRIES) ? lfc_pkg::ENTRIES : phase_caps[p];
      pool_size = eff_cap + $urandom_range(1, 6);
      key_pool.delete();
      repeat (pool_size)
        key_pool.push_back(($urandom_range(0, 9) == 0) ? corner_keys[$urandom_range(0, 3)]
                                                       : $urandom());
      burst = 1'b0;
      for (int n = 0; n < RANDOM_PER_CAP; n++) begin
        if (n % 30 == 0) burst = ($urandom_range(0, 2) == 0);
        if (n == RANDOM_PER_CAP / 2 && p % 3 == 0) plan_drain();
        if ($urandom_range(0, 6) == 0) pick = $urandom();
        else pick = key_pool[$urandom_range(0, pool_size - 1)];
        plan_access(($urandom_range(0, 1) == 1) ? lfc_pkg::OP_PUT : lfc_pkg::OP_GET, pick,
                    $urandom(), burst ? 0 : $urandom_range(0, 18));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for the plan to run dry and every request to answer, then let the
    // pipeline settle so a stray response still gets caught.
    @(posedge clk);
    while (!(driver_idle && accepted_total == retired_total && !busy)) @(posedge clk);
    repeat (lfc_pkg::ENTRIES + 8) @(posedge clk);

    if (mismatches == 0 && accepted_total == retired_total) begin
      $display("[lfu_cache_table] OK");
    end else begin
      $display("[lfu_cache_table] ERROR");
    end
    $finish;
  end

endmodule
